/* sv/rid_pkg.sv */
// Shared types and constants for the remote ID learning table.
`default_nettype none

package rid_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ID_BITS     = 24;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   localparam int OP_W   = 2;
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 10;

   // item opcodes
   localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_W-1:0] OP_CHECK   = 2'd1;
   localparam logic [OP_W-1:0] OP_CAPTURE = 2'd2;

   // register indexes
   localparam logic [CSR_AW-1:0] REG_RELEASE_WINDOW = 2'd0;
   localparam logic [CSR_AW-1:0] REG_ERASE_HOLD     = 2'd1;
   localparam logic [CSR_AW-1:0] REG_BLINK_TICKS    = 2'd2;
   localparam logic [CSR_AW-1:0] REG_MIN_PRESS      = 2'd3;

   localparam logic [9:0] RELEASE_WINDOW_RST = 10'd350;
   localparam logic [9:0] ERASE_HOLD_RST     = 10'd300;
   localparam logic [7:0] BLINK_TICKS_RST    = 8'd30;
   localparam logic [7:0] MIN_PRESS_RST      = 8'd3;

   // search token handed from cell to cell
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [ID_BITS-1:0] key;
   } tok_type;

   // table write broadcast
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   idx;
      logic [ID_BITS-1:0] id;
   } wr_type;

   typedef struct packed {
      logic               led;
      logic               beep;
      logic               store_valid;
      logic [7:0]         store_index;
      logic [ID_BITS-1:0] store_id;
      logic [CNT_W-1:0]   id_count;
      logic               match;
      logic               learn_mode;
      logic               erase_mode;
      logic               table_full;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/rid_if.sv */
// Handshake channel interfaces: request, response and register write.
`default_nettype none

interface rid_req_if import rid_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic               button;
   logic [ID_BITS-1:0] id;
   modport source (output valid, op, button, id, input ready);
   modport sink   (input valid, op, button, id, output ready);
endinterface

interface rid_rsp_if import rid_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               led;
   logic               beep;
   logic               store_valid;
   logic [7:0]         store_index;
   logic [ID_BITS-1:0] store_id;
   logic [CNT_W-1:0]   id_count;
   logic               match;
   logic               learn_mode;
   logic               erase_mode;
   logic               table_full;
   modport source (output valid, led, beep, store_valid, store_index, store_id, id_count,
                   match, learn_mode, erase_mode, table_full, input ready);
   modport sink   (input valid, led, beep, store_valid, store_index, store_id, id_count,
                   match, learn_mode, erase_mode, table_full, output ready);
endinterface

interface rid_csr_if import rid_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CSR_AW-1:0] index;
   logic [CSR_DW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/remote_id_learning_table.sv */
// Top level: button timing, mode control, result register and the cell chain.
//
//   channel | direction | payload
//   req     | in        | op, button, id
//   rsp     | out       | led, beep, store_valid, store_index, store_id,
//           |           | id_count, match, learn_mode, erase_mode, table_full
//   csr     | in        | index, data (register write)
//
// Tick, capture and most check items give their result in the cycle after accept.
// A check on a non-empty table outside erase mode sends a token down the
// TABLE_DEPTH-cell chain, one cell a cycle, then waits in ST_DONE for a free result slot.
// One item is in work at a time; req.ready drops while a check walks or a result
// is held by rsp.ready low. Reset is synchronous; table entries are not cleared.
`default_nettype none

module remote_id_learning_table import rid_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   rid_req_if.sink   req,
   rid_rsp_if.source rsp,
   rid_csr_if.sink   csr
);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_type;

   state_type state_ff;

   logic [9:0] release_window_ff, erase_hold_ff;
   logic [7:0] blink_ticks_ff, min_press_ff;

   logic [9:0]         idle_ff, idle_in;
   logic [9:0]         hold_ff, hold_in;
   logic [7:0]         press_ff, press_in;
   logic               learn_ff, learn_in, erase_ff, erase_in, exit_ff, exit_in;
   logic               pend_ff, pend_in, done_ff, done_in, known_ff, known_in;
   logic               led_ff, led_in;
   logic [7:0]         blink_ff, blink_in;
   logic [ID_BITS-1:0] capt_ff, capt_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;
   logic    accept, out_free, start_walk;
   wr_type  wr;
   tok_type tok_head;
   tok_type chain [TABLE_DEPTH];

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // next state for one accepted item
   always_comb begin
      idle_in    = idle_ff;
      hold_in    = hold_ff;
      press_in   = press_ff;
      learn_in   = learn_ff;
      erase_in   = erase_ff;
      exit_in    = exit_ff;
      pend_in    = pend_ff;
      done_in    = done_ff;
      known_in   = known_ff;
      led_in     = led_ff;
      blink_in   = blink_ff;
      capt_in    = capt_ff;
      count_in   = count_ff;
      wr         = '0;
      start_walk = 1'b0;
      rsp_in     = '0;
      if (accept) begin
         unique case (req.op)
            OP_TICK: begin
               // idle timeout clears press tracking outside a mode
               if (idle_in != '0) begin
                  idle_in = idle_in - 10'd1;
               end else if (!(erase_in || learn_in)) begin
                  hold_in  = '0;
                  press_in = '0;
               end
               if (!req.button) begin
                  if (hold_in < 10'd1023) hold_in = hold_in + 10'd1;
                  idle_in = release_window_ff;
                  if (press_in >= 8'd2) learn_in = 1'b1;
                  if ((erase_in && press_in >= 8'd1) || (learn_in && press_in >= 8'd3)) begin
                     exit_in  = 1'b1;
                     pend_in  = 1'b0;
                     done_in  = 1'b0;
                     learn_in = 1'b0;
                     erase_in = 1'b0;
                     led_in   = 1'b0;
                  end
               end else begin
                  if (hold_in > {2'b00, min_press_ff} && press_in < 8'd255) begin
                     press_in = press_in + 8'd1;
                  end
                  if (exit_in) begin
                     exit_in  = 1'b0;
                     press_in = '0;
                  end
                  hold_in = '0;
               end
               // long hold enters erase mode
               if (hold_in >= erase_hold_ff) begin
                  hold_in  = '0;
                  erase_in = 1'b1;
               end
               // blink and pending capture while in a mode
               if (erase_in || learn_in) begin
                  if (blink_in < 8'd255) blink_in = blink_in + 8'd1;
                  if (blink_in >= blink_ticks_ff) begin
                     blink_in = '0;
                     led_in   = !led_in;
                  end
                  if (pend_in && !done_in) begin
                     done_in = 1'b1;
                     if (known_in) begin
                        known_in = 1'b0;
                     end else begin
                        rsp_in.beep = 1'b1;
                        led_in      = 1'b0;
                        if (!learn_in) count_in = '0;
                        if (count_in < CNT_W'(TABLE_DEPTH)) begin
                           wr.en              = 1'b1;
                           wr.idx             = count_in[IDX_W-1:0];
                           wr.id              = capt_in;
                           rsp_in.store_valid = 1'b1;
                           rsp_in.store_index = 8'(count_in[IDX_W-1:0]);
                           rsp_in.store_id    = capt_in;
                           count_in           = count_in + CNT_W'(1);
                        end else begin
                           rsp_in.table_full = 1'b1;
                        end
                     end
                  end
               end
            end
            OP_CHECK: begin
               if (count_in != '0) begin
                  if (erase_in) known_in = 1'b0;
                  else start_walk = 1'b1;
               end
            end
            OP_CAPTURE: begin
               capt_in = req.id;
               pend_in = 1'b1;
               done_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
      rsp_in.led        = led_in;
      rsp_in.id_count   = count_in;
      rsp_in.match      = known_in;
      rsp_in.learn_mode = learn_in;
      rsp_in.erase_mode = erase_in;
   end

   // token into the head of the chain
   always_comb begin
      tok_head       = '0;
      tok_head.valid = start_walk;
      tok_head.key   = req.id;
   end

   // cell chain
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      rid_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .count      (count_ff),
         .wr         (wr),
         .tok_in     ((i == 0) ? tok_head : chain[(i == 0) ? 0 : i - 1]),
         .tok_out    (chain[i])
      );
   end

   // control, state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         release_window_ff <= RELEASE_WINDOW_RST;
         erase_hold_ff     <= ERASE_HOLD_RST;
         blink_ticks_ff    <= BLINK_TICKS_RST;
         min_press_ff      <= MIN_PRESS_RST;
         idle_ff           <= '0;
         hold_ff           <= '0;
         press_ff          <= '0;
         learn_ff          <= 1'b0;
         erase_ff          <= 1'b0;
         exit_ff           <= 1'b0;
         pend_ff           <= 1'b0;
         done_ff           <= 1'b0;
         known_ff          <= 1'b0;
         led_ff            <= 1'b0;
         blink_ff          <= '0;
         capt_ff           <= '0;
         count_ff          <= '0;
      end else begin
         if (csr.valid) begin
            unique case (csr.index)
               REG_RELEASE_WINDOW: release_window_ff <= csr.data;
               REG_ERASE_HOLD:     erase_hold_ff     <= csr.data;
               REG_BLINK_TICKS:    blink_ticks_ff    <= csr.data[7:0];
               REG_MIN_PRESS:      min_press_ff      <= csr.data[7:0];
               default: begin
               end
            endcase
         end
         if (rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  idle_ff  <= idle_in;
                  hold_ff  <= hold_in;
                  press_ff <= press_in;
                  learn_ff <= learn_in;
                  erase_ff <= erase_in;
                  exit_ff  <= exit_in;
                  pend_ff  <= pend_in;
                  done_ff  <= done_in;
                  known_ff <= known_in;
                  led_ff   <= led_in;
                  blink_ff <= blink_in;
                  capt_ff  <= capt_in;
                  count_ff <= count_in;
                  if (start_walk) begin
                     state_ff <= ST_WALK;
                  end else begin
                     rsp_ff       <= rsp_in;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            ST_WALK: begin
               if (chain[TABLE_DEPTH-1].valid) begin
                  known_ff <= known_ff | chain[TABLE_DEPTH-1].hit;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_ff       <= rsp_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.led         = rsp_ff.led;
   assign rsp.beep        = rsp_ff.beep;
   assign rsp.store_valid = rsp_ff.store_valid;
   assign rsp.store_index = rsp_ff.store_index;
   assign rsp.store_id    = rsp_ff.store_id;
   assign rsp.id_count    = rsp_ff.id_count;
   assign rsp.match       = rsp_ff.match;
   assign rsp.learn_mode  = rsp_ff.learn_mode;
   assign rsp.erase_mode  = rsp_ff.erase_mode;
   assign rsp.table_full  = rsp_ff.table_full;

endmodule

`default_nettype wire

/* sv/rid_cell.sv */
// One table cell: holds one stored ID and compares the passing search token.
`default_nettype none

module rid_cell import rid_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] cell_index,
   input  wire logic [CNT_W-1:0] count,
   input  wire wr_type           wr,
   input  wire tok_type          tok_in,
   output tok_type               tok_out
);

   logic [ID_BITS-1:0] entry_ff;
   tok_type            tok_ff;
   tok_type            tok_in_next;
   logic               live;

   // entry counts only below the fill level
   assign live = {1'b0, cell_index} < count;

   always_comb begin
      tok_in_next     = tok_in;
      tok_in_next.hit = tok_in.hit | (tok_in.valid & live & (entry_ff == tok_in.key));
   end

   // stored ID, written by broadcast
   always_ff @(posedge clock) begin
      if (wr.en && (wr.idx == cell_index)) begin
         entry_ff <= wr.id;
      end
   end

   // token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.hit <= tok_in_next.hit;
      tok_ff.key <= tok_in_next.key;
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for remote_id_learning_table: button sessions, captures and searches.

import rid_pkg::*;

// Tracks the learning table state and the results the block owes.
class learn_table_scoreboard;
   // register copies
   logic [9:0]         release_window, erase_hold;
   logic [7:0]         blink_ticks, min_press;
   // button timing and mode state
   logic [9:0]         idle_timer, hold_time;
   logic [7:0]         press_count, blink_timer;
   logic               learn_on, erase_on, leave_armed;
   logic               capture_armed, capture_taken, known, led_on;
   logic [ID_BITS-1:0] capture_id;
   logic [CNT_W-1:0]   entry_count;
   logic [ID_BITS-1:0] id_table [TABLE_DEPTH];
   rsp_type            cur;
   rsp_type            expected_rsp [$];
   int unsigned        mismatches, results_seen, appends, full_drops, searches, erase_entries;

   function new();
      release_window = RELEASE_WINDOW_RST;
      erase_hold     = ERASE_HOLD_RST;
      blink_ticks    = BLINK_TICKS_RST;
      min_press      = MIN_PRESS_RST;
      idle_timer     = '0;
      hold_time      = '0;
      press_count    = '0;
      blink_timer    = '0;
      learn_on       = 1'b0;
      erase_on       = 1'b0;
      leave_armed    = 1'b0;
      capture_armed  = 1'b0;
      capture_taken  = 1'b0;
      known          = 1'b0;
      led_on         = 1'b0;
      capture_id     = '0;
      entry_count    = '0;
   endfunction

   function void write_reg(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] value);
      case (idx)
         REG_RELEASE_WINDOW: release_window = value[9:0];
         REG_ERASE_HOLD:     erase_hold     = value[9:0];
         REG_BLINK_TICKS:    blink_ticks    = value[7:0];
         REG_MIN_PRESS:      min_press      = value[7:0];
         default: ;
      endcase
   endfunction

   // append the captured ID, or flag the drop when the table is full
   function void append_capture();
      if (entry_count < TABLE_DEPTH) begin
         id_table[entry_count[IDX_W-1:0]] = capture_id;
         cur.store_valid = 1'b1;
         cur.store_index = entry_count[7:0];
         cur.store_id    = capture_id;
         entry_count++;
         appends++;
      end else begin
         cur.table_full = 1'b1;
         full_drops++;
      end
   endfunction

   function void button_tick(logic button);
      // idle counters clear only outside a mode
      if (idle_timer != 0) begin
         idle_timer--;
      end else if (!(erase_on || learn_on)) begin
         hold_time   = '0;
         press_count = '0;
      end
      if (!button) begin
         if (hold_time < 10'd1023) hold_time++;
         idle_timer = release_window;
         if (press_count >= 2) learn_on = 1'b1;
         if ((erase_on && press_count >= 1) || (learn_on && press_count >= 3)) begin
            leave_armed   = 1'b1;
            capture_armed = 1'b0;
            capture_taken = 1'b0;
            learn_on      = 1'b0;
            erase_on      = 1'b0;
            led_on        = 1'b0;
         end
      end else begin
         if (hold_time > min_press && press_count < 8'd255) press_count++;
         if (leave_armed) begin
            leave_armed = 1'b0;
            press_count = '0;
         end
         hold_time = '0;
      end
      // long hold enters erase mode
      if (hold_time >= erase_hold) begin
         hold_time = '0;
         if (!erase_on) erase_entries++;
         erase_on = 1'b1;
      end
      // blink and take a pending capture while in a mode
      if (erase_on || learn_on) begin
         if (blink_timer < 8'd255) blink_timer++;
         if (blink_timer >= blink_ticks) begin
            blink_timer = '0;
            led_on      = ~led_on;
         end
         if (capture_armed && !capture_taken) begin
            capture_taken = 1'b1;
            if (known) begin
               known = 1'b0;
            end else begin
               cur.beep = 1'b1;
               led_on   = 1'b0;
               if (!learn_on) entry_count = '0;
               append_capture();
            end
         end
      end
   endfunction

   function void search_table(logic [ID_BITS-1:0] id);
      if (entry_count == 0) return;
      if (erase_on) begin
         known = 1'b0;
         return;
      end
      for (int i = 0; i < entry_count; i++) begin
         if (id_table[i] == id) begin
            known = 1'b1;
            return;
         end
      end
   endfunction

   // advance the state for one accepted item and queue its result
   function void note_item(logic [OP_W-1:0] op, logic button, logic [ID_BITS-1:0] id);
      cur = '0;
      case (op)
         OP_TICK:    button_tick(button);
         OP_CHECK: begin
            searches++;
            search_table(id);
         end
         OP_CAPTURE: begin
            capture_id    = id;
            capture_armed = 1'b1;
            capture_taken = 1'b0;
         end
         default: ;
      endcase
      cur.led        = led_on;
      cur.id_count   = entry_count;
      cur.match      = known;
      cur.learn_mode = learn_on;
      cur.erase_mode = erase_on;
      expected_rsp.push_back(cur);
   endfunction

   function string describe(rsp_type r);
      return $sformatf({"led=%0b beep=%0b store=%0b idx=%0d id=%06h cnt=%0d match=%0b ",
                        "learn=%0b erase=%0b full=%0b"},
                       r.led, r.beep, r.store_valid, r.store_index, r.store_id, r.id_count,
                       r.match, r.learn_mode, r.erase_mode, r.table_full);
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      results_seen++;
      if (expected_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result %0d: %s", results_seen, describe(got));
         return;
      end
      want = expected_rsp.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch on result %0d", results_seen);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
         end
      end
   endfunction
endclass

module tb;
   localparam int unsigned     CYCLE_LIMIT = 2_000_000;
   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

   logic                  clock;
   logic                  reset;
   bit                    rush;
   bit                    long_stall_req;
   int unsigned           items_sent = 0;
   int unsigned           cycles = 0;
   learn_table_scoreboard sb;

   rid_req_if req ();
   rid_rsp_if rsp ();
   rid_csr_if csr ();

   remote_id_learning_table i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles,
                  sb.expected_rsp.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin : watch_rsp
      rsp_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.led         = rsp.led;
         got.beep        = rsp.beep;
         got.store_valid = rsp.store_valid;
         got.store_index = rsp.store_index;
         got.store_id    = rsp.store_id;
         got.id_count    = rsp.id_count;
         got.match       = rsp.match;
         got.learn_mode  = rsp.learn_mode;
         got.erase_mode  = rsp.erase_mode;
         got.table_full  = rsp.table_full;
         sb.check_result(got);
      end
   end

   // result receiver: random stalls, one long hold-off on request
   initial begin
      int unsigned stall;
      rsp.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_stall_req) begin
            long_stall_req = 1'b0;
            rsp.ready <= 1'b0;
            repeat (250) @(posedge clock);
         end
         stall = rush ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   // valid stays high into the next item when no gap is drawn
   task automatic send_item(logic [OP_W-1:0] op, logic button, logic [ID_BITS-1:0] id);
      int unsigned gap;
      gap = rush ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid  <= 1'b1;
      req.op     <= op;
      req.button <= button;
      req.id     <= id;
      do @(posedge clock); while (!req.ready);
      sb.note_item(op, button, id);
      items_sent++;
   endtask

   task automatic tick(logic button);
      send_item(OP_TICK, button, ID_BITS'($urandom()));
   endtask

   task automatic press(int unsigned held);
      repeat (held) tick(1'b0);
      tick(1'b1);
   endtask

   task automatic noise_item();
      send_item(OP_W'($urandom_range(0, 3)), 1'($urandom()), ID_BITS'($urandom()));
   endtask

   // a stored ID about a third of the time, else a fresh one
   function automatic logic [ID_BITS-1:0] some_remote_id();
      if (sb.entry_count != 0 && $urandom_range(0, 2) == 0)
         return sb.id_table[$urandom_range(0, sb.entry_count - 1)];
      return ID_BITS'($urandom());
   endfunction

   // drain all results so registers can be written
   task automatic quiesce();
      req.valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      sb.write_reg(idx, value);
   endtask

   task automatic configure(logic [9:0] window, logic [9:0] hold, logic [7:0] blink,
                            logic [7:0] minp);
      quiesce();
      csr_write(REG_RELEASE_WINDOW, window);
      csr_write(REG_ERASE_HOLD, hold);
      csr_write(REG_BLINK_TICKS, blink);
      csr_write(REG_MIN_PRESS, minp);
      csr.valid <= 1'b0;
   endtask

   // press until no mode is active
   task automatic leave_modes();
      int unsigned guard;
      guard = 0;
      while ((sb.learn_on || sb.erase_on) && guard < 10) begin
         press(sb.min_press + 1);
         guard++;
      end
   endtask

   task automatic enter_mode(bit erase);
      int unsigned guard;
      leave_modes();
      guard = 0;
      if (erase) begin
         while (!sb.erase_on && guard < sb.erase_hold + 4) begin
            tick(1'b0);
            guard++;
         end
         tick(1'b1);
      end else begin
         while (!sb.learn_on && guard < 8) begin
            press(sb.min_press + 1 + $urandom_range(0, 1));
            guard++;
         end
      end
   endtask

   // captures, searches and filler while a mode is active
   task automatic mode_body(int unsigned n);
      repeat (n) begin
         int unsigned        pick;
         logic [ID_BITS-1:0] id;
         pick = $urandom_range(0, 99);
         id   = some_remote_id();
         if (pick < 50) begin
            send_item(OP_CAPTURE, 1'($urandom()), id);
            tick(1'b1);
         end else if (pick < 65) begin
            send_item(OP_CHECK, 1'($urandom()), id);
         end else if (pick < 75) begin
            // searched right after capture: with the known flag set, the next tick only clears it
            send_item(OP_CAPTURE, 1'($urandom()), id);
            send_item(OP_CHECK, 1'($urandom()), id);
            tick(1'b1);
         end else if (pick < 85) begin
            tick(1'b1);
         end else if (pick < 90) begin
            send_item(OP_UNUSED, 1'($urandom()), id);
         end else begin
            noise_item();
         end
      end
   endtask

   task automatic random_phase(int unsigned quota);
      logic [7:0]  minp;
      logic [7:0]  blink;
      int unsigned target;
      minp = 8'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0:       blink = 8'd1;
         1:       blink = 8'd255;
         default: blink = 8'($urandom_range(2, 40));
      endcase
      configure(10'($urandom_range(12, 100)), 10'($urandom_range(minp + 4, 24)), blink, minp);
      target = items_sent + quota;
      while (items_sent < target) begin
         repeat ($urandom_range(0, 3)) noise_item();
         enter_mode($urandom_range(0, 3) == 0);
         mode_body($urandom_range(3, 10));
      end
   endtask

   // learn until the table is full and at least two appends are dropped
   task automatic fill_table();
      int unsigned drops0;
      int unsigned guard;
      configure(10'd200, 10'd1023, 8'd9, 8'd1);
      enter_mode(1'b0);
      drops0 = sb.full_drops;
      guard  = 0;
      while ((sb.entry_count < TABLE_DEPTH || sb.full_drops < drops0 + 2) && guard < 800) begin
         if ($urandom_range(0, 39) == 0) send_item(OP_CHECK, 1'($urandom()), some_remote_id());
         send_item(OP_CAPTURE, 1'($urandom()), ID_BITS'($urandom()));
         tick(1'b1);
         guard++;
      end
      // full-length searches
      send_item(OP_CHECK, 1'b0, sb.id_table[TABLE_DEPTH-1]);
      send_item(OP_CHECK, 1'b1, ID_BITS'($urandom()));
      leave_modes();
   endtask

   initial begin
      sb         = new();
      reset      = 1'b1;
      req.valid  = 1'b0;
      req.op     = OP_TICK;
      req.button = 1'b1;
      req.id     = '0;
      csr.valid  = 1'b0;
      csr.index  = REG_RELEASE_WINDOW;
      csr.data   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: long window, no erase, fastest blink, any press counts
      configure(10'd1023, 10'd1023, 8'd1, 8'd0);
      send_item(OP_UNUSED, 1'b1, '1);
      send_item(OP_CHECK, 1'b0, '0);              // search of an empty table
      send_item(OP_CAPTURE, 1'b1, 24'hFFFFFF);    // held until a mode starts
      tick(1'b0);
      tick(1'b1);
      tick(1'b0);
      tick(1'b1);
      tick(1'b0);                                  // third press enters learn mode
      tick(1'b1);
      send_item(OP_CHECK, 1'b1, 24'hFFFFFF);      // hit
      send_item(OP_CHECK, 1'b0, 24'h000000);      // miss keeps the known flag
      send_item(OP_CAPTURE, 1'b0, 24'hFFFFFF);
      tick(1'b1);                                  // known ID: nothing stored
      send_item(OP_CAPTURE, 1'b1, 24'h000000);
      tick(1'b1);
      send_item(OP_UNUSED, 1'b0, '0);

      // directed: shortest window, instant erase, slowest blink, longest press
      configure(10'd1, 10'd1, 8'd255, 8'd255);
      tick(1'b0);
      send_item(OP_CHECK, 1'b1, 24'h123456);      // erase mode clears the known flag
      send_item(OP_CAPTURE, 1'b0, 24'hAAAAAA);
      tick(1'b1);                                  // table emptied, then appended
      send_item(OP_CHECK, 1'b0, 24'h555555);
      tick(1'b0);
      tick(1'b1);

      // random sessions; the second phase stalls the receiver, the third never idles
      for (int p = 0; p < 3; p++) begin
         rush = (p == 2);
         if (p == 1) long_stall_req = 1'b1;
         random_phase(10);
      end
      rush = 1'($urandom_range(0, 1));
      fill_table();
      rush = 1'b0;
      random_phase(10);

      // drain and let any search in flight finish
      req.valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 20) @(posedge clock);

      $display("covered %0d items: %0d searches, %0d appends,", items_sent, sb.searches,
               sb.appends);
      $display("  %0d drops on a full table, %0d erases, %0d results checked",
               sb.full_drops, sb.erase_entries, sb.results_seen);
      $display("%0d mismatches, %0d still expected", sb.mismatches, sb.expected_rsp.size());
      if (sb.mismatches == 0 && sb.expected_rsp.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

/* files.f */
sv/rid_pkg.sv
sv/rid_if.sv
sv/rid_cell.sv
sv/remote_id_learning_table.sv
tb/sv/tb.sv
